// ===== hw/rtl/sync_marker_pixel_deframer_unit_macros.svh =====
// assertion macros for the sync marker pixel deframer
`ifndef SYNC_MARKER_PIXEL_DEFRAMER_UNIT_MACROS_SVH
`define SYNC_MARKER_PIXEL_DEFRAMER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define SMPD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("smpd assertion failed");
`define SMPD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("smpd assertion failed");
`else
`define SMPD_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SMPD_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== hw/rtl/smpd_pkg.sv =====
package smpd_pkg;

  localparam logic [7:0] SYNC_BYTE = 8'hFF;
  localparam logic [23:0] SYNC_HELD = 24'hFFFFFF;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;
  localparam logic [CFG_DATA_W-1:0] REG_SIZE_RESET = 11'd640;

  localparam int IDX_W = 10;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_LINE_END = 1'b1;

  typedef struct packed {
    logic             result_kind;
    logic [IDX_W-1:0] row_index;
    logic [IDX_W-1:0] column_index;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic             line_last;
    logic             frame_last;
  } result_t;

endpackage

// ===== hw/rtl/smpd_if.sv =====
interface smpd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface smpd_result_if import smpd_pkg::*;;
  logic             valid;
  logic             ready;
  logic             result_kind;
  logic [IDX_W-1:0] row_index;
  logic [IDX_W-1:0] column_index;
  logic [7:0]       red;
  logic [7:0]       green;
  logic [7:0]       blue;
  logic             line_last;
  logic             frame_last;

  modport source (output valid, output result_kind, output row_index,
                  output column_index, output red, output green, output blue,
                  output line_last, output frame_last, input ready);
  modport sink (input valid, input result_kind, input row_index,
                input column_index, input red, input green, input blue,
                input line_last, input frame_last, output ready);
endinterface

// ===== hw/rtl/smpd_cfg_regs.sv =====
module smpd_cfg_regs import smpd_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 1024,
  localparam int WEW = $clog2(MAX_WIDTH + 1),
  localparam int HEW = $clog2(MAX_HEIGHT + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic [WEW-1:0]        eff_width,
  output logic [HEW-1:0]        eff_height
);

  localparam int WCW = (WEW > CFG_DATA_W) ? WEW : CFG_DATA_W;
  localparam int HCW = (HEW > CFG_DATA_W) ? HEW : CFG_DATA_W;

  logic [CFG_DATA_W-1:0] width_r;
  logic [CFG_DATA_W-1:0] height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= REG_SIZE_RESET;
      height_r <= REG_SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LINE_WIDTH: begin
          width_r <= cfg_data;
        end
        REG_FRAME_HEIGHT: begin
          height_r <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  // zero acts as one, above maximum acts as maximum
  always_comb begin
    if (width_r == '0) begin
      eff_width = WEW'(1);
    end else if (WCW'(width_r) > WCW'(MAX_WIDTH)) begin
      eff_width = WEW'(MAX_WIDTH);
    end else begin
      eff_width = WEW'(width_r);
    end
  end

  always_comb begin
    if (height_r == '0) begin
      eff_height = HEW'(1);
    end else if (HCW'(height_r) > HCW'(MAX_HEIGHT)) begin
      eff_height = HEW'(MAX_HEIGHT);
    end else begin
      eff_height = HEW'(height_r);
    end
  end

endmodule

// ===== hw/rtl/smpd_core.sv =====
module smpd_core import smpd_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 1024,
  localparam int WEW = $clog2(MAX_WIDTH + 1),
  localparam int HEW = $clog2(MAX_HEIGHT + 1)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     in_data_byte,
  input  logic [WEW-1:0] eff_width,
  input  logic [HEW-1:0] eff_height,
  input  logic           slot_free,
  output logic           res_load,
  output result_t        res
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  // input register
  logic       stage_v_r;
  logic [7:0] stage_byte_r;

  // deframer state
  logic          in_line_r, in_line_nxt;
  logic [1:0]    ff_run_r, ff_run_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic [23:0]   held_r, held_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;

  logic          has_result;
  logic          advance;
  logic          marker_word;
  logic          line_end;
  logic          frame_end;
  logic [WEW:0]  col_inc;
  logic [HEW:0]  row_inc;

  assign col_inc = (WEW + 1)'(col_r) + (WEW + 1)'(1);
  assign row_inc = (HEW + 1)'(row_r) + (HEW + 1)'(1);
  assign line_end = col_inc >= {1'b0, eff_width};
  assign frame_end = row_inc >= {1'b0, eff_height};
  assign marker_word = (held_r == SYNC_HELD) && (stage_byte_r == SYNC_BYTE);

  assign has_result = in_line_r && (phase_r == 2'd3);
  assign advance = stage_v_r && (!has_result || slot_free);
  assign in_ready = !stage_v_r || advance;
  assign res_load = advance && has_result;

  always_comb begin
    in_line_nxt = in_line_r;
    ff_run_nxt  = ff_run_r;
    phase_nxt   = phase_r;
    held_nxt    = held_r;
    col_nxt     = col_r;
    row_nxt     = row_r;

    res.result_kind  = marker_word ? KIND_LINE_END : KIND_PIXEL;
    res.row_index    = IDX_W'(row_r);
    res.column_index = marker_word ? '0 : IDX_W'(col_r);
    res.red          = marker_word ? 8'd0 : held_r[7:0];
    res.green        = marker_word ? 8'd0 : held_r[15:8];
    res.blue         = marker_word ? 8'd0 : held_r[23:16];
    res.line_last    = marker_word || line_end;
    res.frame_last   = (marker_word || line_end) && frame_end;

    if (!in_line_r) begin
      if (stage_byte_r == SYNC_BYTE) begin
        if (ff_run_r == 2'd3) begin
          in_line_nxt = 1'b1;
          ff_run_nxt  = 2'd0;
          phase_nxt   = 2'd0;
          col_nxt     = '0;
        end else begin
          ff_run_nxt = ff_run_r + 2'd1;
        end
      end else begin
        ff_run_nxt = 2'd0;
      end
    end else if (phase_r != 2'd3) begin
      case (phase_r)
        2'd0: held_nxt[7:0] = stage_byte_r;
        2'd1: held_nxt[15:8] = stage_byte_r;
        default: held_nxt[23:16] = stage_byte_r;
      endcase
      phase_nxt = phase_r + 2'd1;
    end else begin
      phase_nxt = 2'd0;
      if (marker_word || line_end) begin
        col_nxt = '0;
        if (frame_end) begin
          row_nxt     = '0;
          in_line_nxt = 1'b0;
          ff_run_nxt  = 2'd0;
        end else begin
          row_nxt = RW'(row_inc);
        end
        // a full line goes back to hunting
        if (!marker_word) begin
          in_line_nxt = 1'b0;
          ff_run_nxt  = 2'd0;
        end
      end else begin
        col_nxt = CW'(col_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
      in_line_r <= 1'b0;
      ff_run_r  <= 2'd0;
      phase_r   <= 2'd0;
      col_r     <= '0;
      row_r     <= '0;
    end else begin
      if (in_valid && in_ready) begin
        stage_v_r <= 1'b1;
      end else if (advance) begin
        stage_v_r <= 1'b0;
      end
      if (advance) begin
        in_line_r <= in_line_nxt;
        ff_run_r  <= ff_run_nxt;
        phase_r   <= phase_nxt;
        col_r     <= col_nxt;
        row_r     <= row_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_byte_r <= in_data_byte;
    end
    if (advance) begin
      held_r <= held_nxt;
    end
  end

endmodule

// ===== hw/rtl/smpd_out_reg.sv =====
module smpd_out_reg import smpd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    res_load,
  input  result_t res,
  output logic    slot_free,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_word
);

  logic    valid_r;
  result_t word_r;

  assign slot_free = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_word = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      word_r <= res;
    end
  end

endmodule

// ===== hw/rtl/sync_marker_pixel_deframer_unit.sv =====
// a byte is registered in the input register at acceptance, its result word then in the output register
// throughput: one byte per cycle unless the result register is held, set by the single state update per input register
// a pixel word leaves every fourth byte; stalls only while the result register is held
// reset: synchronous active-low rst_n clears state to hunting, sizes return to 640
`include "sync_marker_pixel_deframer_unit_macros.svh"

module sync_marker_pixel_deframer_unit import smpd_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  smpd_byte_if.sink             in_ch,
  smpd_result_if.source         out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int WEW = $clog2(MAX_WIDTH + 1);
  localparam int HEW = $clog2(MAX_HEIGHT + 1);

  logic [WEW-1:0] eff_width;
  logic [HEW-1:0] eff_height;
  logic           slot_free;
  logic           res_load;
  result_t        res;
  result_t        out_word;

  smpd_cfg_regs #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .eff_width  (eff_width),
    .eff_height (eff_height)
  );

  smpd_core #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_data_byte (in_ch.data_byte),
    .eff_width    (eff_width),
    .eff_height   (eff_height),
    .slot_free    (slot_free),
    .res_load     (res_load),
    .res          (res)
  );

  smpd_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_load  (res_load),
    .res       (res),
    .slot_free (slot_free),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_word  (out_word)
  );

  assign out_ch.result_kind  = out_word.result_kind;
  assign out_ch.row_index    = out_word.row_index;
  assign out_ch.column_index = out_word.column_index;
  assign out_ch.red          = out_word.red;
  assign out_ch.green        = out_word.green;
  assign out_ch.blue         = out_word.blue;
  assign out_ch.line_last    = out_word.line_last;
  assign out_ch.frame_last   = out_word.frame_last;

  `SMPD_ASSERT_IMP(a_load_free, clk, rst_n, res_load, !out_ch.valid || out_ch.ready)
  `SMPD_ASSERT_NXT(a_load_shows, clk, rst_n, res_load, out_ch.valid)
  `SMPD_ASSERT_IMP(a_frame_ends_line, clk, rst_n, out_ch.valid && out_ch.frame_last,
                   out_ch.line_last)
  `SMPD_ASSERT_IMP(a_early_end_word, clk, rst_n,
                   out_ch.valid && (out_ch.result_kind == KIND_LINE_END),
                   out_ch.line_last && (out_ch.column_index == '0))

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import smpd_pkg::*;

  localparam int SIZE_LIMIT = 1024;
  localparam int LONG_HOLD = 300;
  localparam int QUIET_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 4;
  localparam int RANDOM_BYTES = 1200;
  localparam int DIR_ROWS = 28;

  typedef enum int {RX_OPEN, RX_PATTERN, RX_LIGHT, RX_HEAVY} stall_mode_e;

  typedef struct packed {
    logic [7:0] data;
    logic       typed;
    logic       gives_word;
    result_t    word;
  } byte_row_t;

  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] value;
    byte_row_t             item;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  logic    row_is_typed;
  logic    row_gives_word;
  result_t row_word;
  logic    hold_req;

  smpd_byte_if in_bus ();
  smpd_result_if out_bus ();

  sync_marker_pixel_deframer_unit #(
    .MAX_WIDTH(SIZE_LIMIT),
    .MAX_HEIGHT(SIZE_LIMIT)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_bus),
    .out_ch(out_bus),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // deframer state mirrored by the testbench
  logic [CFG_DATA_W-1:0] width_reg;
  logic [CFG_DATA_W-1:0] height_reg;
  logic                  line_open;
  logic [1:0]            sync_run;
  logic [1:0]            byte_slot;
  logic [23:0]           pixel_bytes;
  logic [IDX_W-1:0]      col_pos;
  logic [IDX_W-1:0]      row_pos;

  result_t   expected_words[$];
  byte_row_t tx_queue[$];
  dir_row_t  directed_table [0:DIR_ROWS-1];
  int        mismatches;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int eff_size(input logic [CFG_DATA_W-1:0] r, input int lim);
    if (r == '0) return 1;
    if (int'(r) > lim) return lim;
    return int'(r);
  endfunction

  function automatic logic close_row(input int h);
    logic done;
    done = (int'(row_pos) + 1) >= h;
    col_pos = '0;
    byte_slot = '0;
    pixel_bytes = '0;
    if (done) begin
      row_pos = '0;
      line_open = 1'b0;
      sync_run = '0;
    end else begin
      row_pos = row_pos + 1'b1;
    end
    return done;
  endfunction

  function automatic logic deframe_byte(input logic [7:0] b, output result_t res);
    int w;
    int h;
    w = eff_size(width_reg, SIZE_LIMIT);
    h = eff_size(height_reg, SIZE_LIMIT);
    res = '0;
    if (!line_open) begin
      if (b == SYNC_BYTE) begin
        if (sync_run == 2'd3) begin
          line_open = 1'b1;
          sync_run = '0;
          byte_slot = '0;
          pixel_bytes = '0;
          col_pos = '0;
        end else begin
          sync_run = sync_run + 1'b1;
        end
      end else begin
        sync_run = '0;
      end
      return 1'b0;
    end
    if (byte_slot < 2'd3) begin
      pixel_bytes[byte_slot*8 +: 8] = b;
      byte_slot = byte_slot + 1'b1;
      return 1'b0;
    end
    res.row_index = row_pos;
    if (pixel_bytes == SYNC_HELD && b == SYNC_BYTE) begin
      res.result_kind = KIND_LINE_END;
      res.line_last = 1'b1;
      res.frame_last = close_row(h);
      return 1'b1;
    end
    res.result_kind = KIND_PIXEL;
    res.column_index = col_pos;
    res.red = pixel_bytes[7:0];
    res.green = pixel_bytes[15:8];
    res.blue = pixel_bytes[23:16];
    if ((int'(col_pos) + 1) >= w) begin
      res.line_last = 1'b1;
      res.frame_last = close_row(h);
      line_open = 1'b0;
      sync_run = '0;
    end else begin
      col_pos = col_pos + 1'b1;
      byte_slot = '0;
      pixel_bytes = '0;
    end
    return 1'b1;
  endfunction

  function automatic result_t pixel_word(input int row, input int col, input logic [7:0] r,
                                         input logic [7:0] g, input logic [7:0] b,
                                         input logic ll, input logic fl);
    result_t res;
    res.result_kind = KIND_PIXEL;
    res.row_index = IDX_W'(row);
    res.column_index = IDX_W'(col);
    res.red = r;
    res.green = g;
    res.blue = b;
    res.line_last = ll;
    res.frame_last = fl;
    return res;
  endfunction

  function automatic result_t line_end_word(input int row, input logic fl);
    result_t res;
    res = '0;
    res.result_kind = KIND_LINE_END;
    res.row_index = IDX_W'(row);
    res.line_last = 1'b1;
    res.frame_last = fl;
    return res;
  endfunction

  function automatic dir_row_t raw_byte(input logic [7:0] b);
    dir_row_t d;
    d = '0;
    d.item.data = b;
    return d;
  endfunction

  function automatic dir_row_t byte_no_word(input logic [7:0] b);
    dir_row_t d;
    d = raw_byte(b);
    d.item.typed = 1'b1;
    return d;
  endfunction

  function automatic dir_row_t byte_with_word(input logic [7:0] b, input result_t res);
    dir_row_t d;
    d = byte_no_word(b);
    d.item.gives_word = 1'b1;
    d.item.word = res;
    return d;
  endfunction

  function automatic dir_row_t reg_write(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] val);
    dir_row_t d;
    d = '0;
    d.is_cfg = 1'b1;
    d.reg_idx = idx;
    d.value = val;
    return d;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 11'd1;
      2: return '1;
      3: return 11'd1024;
      4: return 11'd1025;
      5: return 11'($urandom_range(9, 40));
      default: return 11'($urandom_range(1, 8));
    endcase
  endfunction

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      mismatches++;
      $display("%0t mismatch on %s: expected %0h actual %0h", $time, name, exp_val, act_val);
    end
  endtask

  always @(posedge clk) begin
    result_t pred;
    result_t got;
    logic    has;
    if (rst_n) begin
      if (cfg_we) begin
        if (cfg_index == REG_LINE_WIDTH) width_reg = cfg_data;
        else if (cfg_index == REG_FRAME_HEIGHT) height_reg = cfg_data;
      end
      if (in_bus.valid && in_bus.ready) begin
        has = deframe_byte(in_bus.data_byte, pred);
        if (row_is_typed) begin
          has = row_gives_word;
          pred = row_word;
        end
        if (has) expected_words.push_back(pred);
      end
      if (out_bus.valid && out_bus.ready) begin
        got.result_kind = out_bus.result_kind;
        got.row_index = out_bus.row_index;
        got.column_index = out_bus.column_index;
        got.red = out_bus.red;
        got.green = out_bus.green;
        got.blue = out_bus.blue;
        got.line_last = out_bus.line_last;
        got.frame_last = out_bus.frame_last;
        if (expected_words.size() == 0) begin
          mismatches++;
          $display("%0t unexpected result word: expected none, actual kind %0d row %0d col %0d",
                   $time, got.result_kind, got.row_index, got.column_index);
        end else begin
          pred = expected_words.pop_front();
          check_field("result_kind", pred.result_kind, got.result_kind);
          check_field("row_index", pred.row_index, got.row_index);
          check_field("column_index", pred.column_index, got.column_index);
          check_field("red", pred.red, got.red);
          check_field("green", pred.green, got.green);
          check_field("blue", pred.blue, got.blue);
          check_field("line_last", pred.line_last, got.line_last);
          check_field("frame_last", pred.frame_last, got.frame_last);
        end
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    wait (rst_n === 1'b1);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) || cfg_we)
        quiet = 0;
      else
        quiet++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    stall_mode_e mode;
    int          mode_left;
    logic [7:0]  pattern;
    logic        held_once;
    mode = RX_OPEN;
    mode_left = 0;
    pattern = 8'hFF;
    held_once = 1'b0;
    out_bus.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_req && !held_once) begin
        out_bus.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        held_once = 1'b1;
        mode_left = 0;
      end else begin
        if (mode_left == 0) begin
          mode = stall_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 128);
          pattern = 8'($urandom);
        end
        mode_left--;
        case (mode)
          RX_OPEN: out_bus.ready <= 1'b1;
          RX_PATTERN: begin
            out_bus.ready <= pattern[0];
            pattern = {pattern[0], pattern[7:1]};
          end
          RX_LIGHT: out_bus.ready <= ($urandom_range(0, 2) != 0);
          default: out_bus.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic queue_byte(input logic [7:0] b);
    byte_row_t r;
    r = '0;
    r.data = b;
    tx_queue.push_back(r);
  endtask

  task automatic queue_pixel();
    repeat (4) queue_byte(($urandom_range(0, 4) == 0) ? SYNC_BYTE : 8'($urandom));
  endtask

  task automatic build_traffic(input int target, input int eff_w);
    int n;
    while (tx_queue.size() < target) begin
      n = $urandom_range(0, 99);
      if (n < 60) begin
        // marker, a line of pixels, sometimes an early end and more pixels
        repeat (($urandom_range(0, 3) == 0) ? $urandom_range(5, 7) : 4) queue_byte(SYNC_BYTE);
        repeat ($urandom_range(1, ((eff_w < 10) ? eff_w : 10) + 1)) queue_pixel();
        if ($urandom_range(0, 3) == 0) begin
          repeat (4) queue_byte(SYNC_BYTE);
          repeat ($urandom_range(0, 3)) queue_pixel();
        end
      end else if (n < 75) begin
        repeat ($urandom_range(1, 8))
          queue_byte(($urandom_range(0, 1) == 0) ? SYNC_BYTE : 8'($urandom));
      end else if (n < 87) begin
        // broken marker
        repeat ($urandom_range(1, 3)) queue_byte(SYNC_BYTE);
        queue_byte(8'($urandom_range(0, 254)));
      end else begin
        repeat ($urandom_range(1, 4)) queue_pixel();
      end
    end
  endtask

  task automatic send_queue();
    byte_row_t r;
    int        burst;
    int        gap;
    burst = 0;
    while (tx_queue.size() != 0) begin
      if (burst == 0) begin
        if ($urandom_range(0, 7) == 0) begin
          gap = 0;
          burst = $urandom_range(100, 250);
        end else begin
          gap = ($urandom_range(0, 5) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 6);
          burst = $urandom_range(1, 40);
        end
        if (gap > 0) begin
          in_bus.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      r = tx_queue.pop_front();
      in_bus.valid <= 1'b1;
      in_bus.data_byte <= r.data;
      row_is_typed <= r.typed;
      row_gives_word <= r.gives_word;
      row_word <= r.word;
      @(posedge clk);
      while (!in_bus.ready) @(posedge clk);
      burst--;
    end
    in_bus.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int random_sent;
    int phase;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_bus.valid = 1'b0;
    in_bus.data_byte = '0;
    row_is_typed = 1'b0;
    row_gives_word = 1'b0;
    row_word = '0;
    hold_req = 1'b0;
    mismatches = 0;
    width_reg = REG_SIZE_RESET;
    height_reg = REG_SIZE_RESET;
    line_open = 1'b0;
    sync_run = '0;
    byte_slot = '0;
    pixel_bytes = '0;
    col_pos = '0;
    row_pos = '0;

    directed_table = '{
      raw_byte(8'hFF), raw_byte(8'hFF), raw_byte(8'hFF), raw_byte(8'hFF),
      byte_no_word(8'h00), byte_no_word(8'h00), byte_no_word(8'h00),
      byte_with_word(8'h00, pixel_word(0, 0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0)),
      raw_byte(8'hFF), raw_byte(8'hFF), raw_byte(8'hFF),
      byte_with_word(8'hFF, line_end_word(0, 1'b0)),
      reg_write(REG_FRAME_HEIGHT, 11'd0),
      raw_byte(8'hFF), raw_byte(8'hFF), raw_byte(8'hFF),
      byte_with_word(8'hFF, line_end_word(1, 1'b1)),
      reg_write(REG_LINE_WIDTH, 11'd0),
      // a fifth sync byte becomes the red byte
      raw_byte(8'hFF), raw_byte(8'hFF), raw_byte(8'hFF), raw_byte(8'hFF),
      raw_byte(8'hFF), raw_byte(8'h12), raw_byte(8'h34),
      byte_with_word(8'hAB, pixel_word(0, 0, 8'hFF, 8'h12, 8'h34, 1'b1, 1'b1)),
      reg_write(REG_LINE_WIDTH, 11'h7FF),
      reg_write(REG_FRAME_HEIGHT, 11'h7FF)
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (directed_table[i].is_cfg) begin
        send_queue();
        wait_idle();
        write_reg(directed_table[i].reg_idx, directed_table[i].value);
      end else begin
        tx_queue.push_back(directed_table[i].item);
      end
    end
    send_queue();

    random_sent = 0;
    phase = 0;
    while (random_sent < RANDOM_BYTES) begin
      wait_idle();
      if ($urandom_range(0, 3) != 0) write_reg(REG_LINE_WIDTH, pick_size());
      if ($urandom_range(0, 3) != 0) write_reg(REG_FRAME_HEIGHT, pick_size());
      build_traffic($urandom_range(100, 200), eff_size(width_reg, SIZE_LIMIT));
      random_sent += tx_queue.size();
      if (phase == 1) hold_req <= 1'b1;
      send_queue();
      phase++;
    end

    wait_idle();
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/smpd_pkg.sv
hw/rtl/smpd_if.sv
hw/rtl/smpd_cfg_regs.sv
hw/rtl/smpd_core.sv
hw/rtl/smpd_out_reg.sv
hw/rtl/sync_marker_pixel_deframer_unit.sv
test/testbench.sv
